// ===== sv/rc4_pkg.sv =====
// Shared types and state codes for the RC4 cipher engine.
`timescale 1ns / 1ps

package rc4_pkg;

  // Word accepted on the input channel.
  typedef struct packed {
    logic       mode;
    logic [7:0] data_value;
    logic       last;
  } in_word_t;

  // Word delivered on the output channel.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       no_key;
  } out_word_t;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  localparam int unsigned SBOX_DEPTH = 256;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PASS,
    ST_KINC,
    ST_KRDI,
    ST_KJ,
    ST_KRDJ,
    ST_KWI,
    ST_KWJ,
    ST_KRDT,
    ST_KOUT,
    ST_SINIT,
    ST_SRDN,
    ST_SADDS,
    ST_SADDK,
    ST_SRDA,
    ST_SWN,
    ST_SWA
  } state_t;

endpackage

// ===== sv/rc4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rc4_stream_cipher_top.sv =====
// RC4 cipher engine: key loading, key schedule, keystream XOR and flagged pass-through.
//
//  channel | handshake                  | word
//  --------+----------------------------+-------------------------------
//  input   | item_valid / item_ready    | item   (mode, data_value, last)
//  output  | result_valid / result_ready| result (out_byte, out_last, no_key)
//
// A key byte is stored as it is accepted. A data byte runs through states
// KINC, KRDI, KJ, KRDJ, KWI, KWJ, KRDT and KOUT to the output register (one
// S-box RAM port, five dependent reads and writes); the next word is taken
// once the engine is back in IDLE. A last key byte, or a last data byte
// with a key loaded, starts a key schedule (identity fill, then six steps
// per swap through the same S-box port); item_ready stays low meanwhile.
// Reset (rst, synchronous) clears control state only; RAM contents are
// not cleared. A stalled output holds the engine in its output state.
`timescale 1ns / 1ps

module rc4_stream_cipher_top
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_BYTES_MAX = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_word_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_word_t result
);

  localparam int unsigned KAW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int unsigned KLW = $clog2(KEY_BYTES_MAX + 1);
  localparam logic [KLW-1:0] KLEN_MAX = KLW'(KEY_BYTES_MAX);

  state_t state, state_next;

  // Control and index registers
  logic [KLW-1:0] klen;
  logic           key_ready;
  logic [7:0]     i, j, acc, n, tsum;
  logic [KAW-1:0] kidx;

  // Payload registers
  logic [7:0] hold;
  logic [7:0] kb;
  logic [7:0] value;
  logic       last;

  // RAM ports
  logic           sb_we;
  logic [7:0]     sb_waddr, sb_wdata, sb_raddr, sb_rdata;
  logic           ks_we;
  logic [KAW-1:0] ks_waddr;
  logic [7:0]     ks_rdata;

  // Shared adder
  logic [7:0] add_a, add_b, add_sum;

  logic           accept;
  logic           out_free;
  logic           load_result;
  logic [KLW-1:0] eff_len;
  logic [KLW-1:0] kidx_inc;
  logic           kidx_wrap;

  assign item_ready  = (state == ST_IDLE);
  assign accept      = item_valid && item_ready;
  assign out_free    = !result_valid || result_ready;
  assign load_result = ((state == ST_PASS) || (state == ST_KOUT)) && out_free;
  assign eff_len     = key_ready ? '0 : klen;
  assign kidx_inc    = KLW'(kidx) + KLW'(1);
  assign kidx_wrap   = (kidx_inc >= klen);
  assign add_sum     = add_a + add_b;

  assign ks_we    = accept && (item.mode == MODE_KEY) && (eff_len < KLEN_MAX);
  assign ks_waddr = eff_len[KAW-1:0];

  rc4_ram #(.WIDTH(8), .DEPTH(SBOX_DEPTH)) u_sbox (
    .clk   (clk),
    .we    (sb_we),
    .waddr (sb_waddr),
    .wdata (sb_wdata),
    .raddr (sb_raddr),
    .rdata (sb_rdata)
  );

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_BYTES_MAX)) u_key (
    .clk   (clk),
    .we    (ks_we),
    .waddr (ks_waddr),
    .wdata (item.data_value),
    .raddr (kidx),
    .rdata (ks_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.mode == MODE_KEY) begin
            state_next = item.last ? ST_SINIT : ST_IDLE;
          end else begin
            state_next = key_ready ? ST_KINC : ST_PASS;
          end
        end
      end
      ST_PASS:  if (out_free) state_next = ST_IDLE;
      ST_KINC:  state_next = ST_KRDI;
      ST_KRDI:  state_next = ST_KJ;
      ST_KJ:    state_next = ST_KRDJ;
      ST_KRDJ:  state_next = ST_KWI;
      ST_KWI:   state_next = ST_KWJ;
      ST_KWJ:   state_next = ST_KRDT;
      ST_KRDT:  state_next = ST_KOUT;
      ST_KOUT:  if (out_free) state_next = last ? ST_SINIT : ST_IDLE;
      ST_SINIT: if (n == 8'hFF) state_next = ST_SRDN;
      ST_SRDN:  state_next = ST_SADDS;
      ST_SADDS: state_next = ST_SADDK;
      ST_SADDK: state_next = ST_SRDA;
      ST_SRDA:  state_next = ST_SWN;
      ST_SWN:   state_next = ST_SWA;
      ST_SWA:   state_next = (n == 8'hFF) ? ST_IDLE : ST_SRDN;
      default:  state_next = ST_IDLE;
    endcase
  end

  // RAM port and adder operand selection
  always_comb begin
    sb_we    = 1'b0;
    sb_waddr = n;
    sb_wdata = n;
    sb_raddr = tsum;
    add_a    = acc;
    add_b    = sb_rdata;
    case (state)
      ST_KINC: begin
        add_a = i;
        add_b = 8'd1;
      end
      ST_KRDI:  sb_raddr = i;
      ST_KJ:    add_a = j;
      ST_KRDJ:  sb_raddr = j;
      ST_KWI: begin
        sb_we    = 1'b1;
        sb_waddr = i;
        sb_wdata = sb_rdata;
        add_a    = hold;
      end
      ST_KWJ: begin
        sb_we    = 1'b1;
        sb_waddr = j;
        sb_wdata = hold;
      end
      ST_SINIT: sb_we = 1'b1;
      ST_SRDN:  sb_raddr = n;
      ST_SADDS: add_a = acc;
      ST_SADDK: add_b = kb;
      ST_SRDA:  sb_raddr = acc;
      ST_SWN: begin
        sb_we    = 1'b1;
        sb_wdata = sb_rdata;
      end
      ST_SWA: begin
        sb_we    = 1'b1;
        sb_waddr = acc;
        sb_wdata = hold;
      end
      default: begin
        sb_we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      klen         <= '0;
      key_ready    <= 1'b0;
      i            <= '0;
      j            <= '0;
      n            <= '0;
      acc          <= '0;
      kidx         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Raise the result flag on a load, drop it once the word is taken
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          // Store a key byte, restarting the key if one was complete
          if (accept && (item.mode == MODE_KEY)) begin
            klen <= eff_len + KLW'(eff_len < KLEN_MAX);
            key_ready <= item.last;
          end
        end
        ST_KINC:  i <= add_sum;
        ST_KJ:    j <= add_sum;
        ST_SINIT: begin
          n    <= n + 8'd1;
          acc  <= '0;
          kidx <= '0;
        end
        ST_SADDS: acc <= add_sum;
        ST_SADDK: acc <= add_sum;
        ST_SWA: begin
          // Advance the swap position and the wrapping key index; clear i and j after the last swap
          n    <= n + 8'd1;
          kidx <= kidx_wrap ? '0 : kidx_inc[KAW-1:0];
          if (n == 8'hFF) begin
            i <= '0;
            j <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      value <= item.data_value;
      last  <= item.last;
    end
    case (state)
      ST_KJ:    hold <= sb_rdata;
      ST_KWI:   tsum <= add_sum;
      ST_SADDS: begin
        hold <= sb_rdata;
        kb   <= (klen == '0) ? 8'd0 : ks_rdata;
      end
      ST_PASS: begin
        if (out_free) begin
          result.out_byte <= value;
          result.out_last <= last;
          result.no_key   <= 1'b1;
        end
      end
      ST_KOUT: begin
        if (out_free) begin
          result.out_byte <= value ^ sb_rdata;
          result.out_last <= last;
          result.no_key   <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_sched_clears_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWA && n == 8'hFF) |=> (i == 8'd0 && j == 8'd0))
    else $error("key schedule left nonzero indices");

  a_klen_bound: assert property (@(posedge clk) disable iff (rst)
    klen <= KLEN_MAX)
    else $error("key length beyond limit");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_KOUT || $past(state) == ST_PASS))
    else $error("result word loaded outside an output state");

  a_keystream_keyed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KINC) |-> key_ready)
    else $error("keystream step without a loaded key");

  a_swap_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KWI) |=> (state == ST_KWJ))
    else $error("swap split across other states");

endmodule

// ===== tb/sv/rc4_stream_cipher_top_test.sv =====
// Self-checking testbench for the RC4 cipher engine with a keystream scoreboard.
`timescale 1ns / 1ps

module rc4_stream_cipher_top_test;
  import rc4_pkg::*;

  localparam int unsigned KEY_BYTES_MAX = 256;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES  = 2000;
  localparam int unsigned PHASE_WORDS   = 50;

  // Track the RC4 state and hold the bytes the engine owes on its output.
  class rc4_cipher_scoreboard;
    logic [7:0]  perm [256];
    logic [7:0]  key_bytes [256];
    int unsigned key_len;
    logic [7:0]  idx_i;
    logic [7:0]  idx_j;
    bit          key_loaded;
    out_word_t   owed_words [$];
    int unsigned errors;

    function new();
      key_len    = 0;
      idx_i      = '0;
      idx_j      = '0;
      key_loaded = 1'b0;
      errors     = 0;
    endfunction

    // Run the key schedule over the stored key and clear the indices.
    function void schedule_perm();
      logic [7:0] acc;
      logic [7:0] tmp;
      int         n;
      acc = '0;
      for (n = 0; n < 256; n++) perm[n] = n[7:0];
      for (n = 0; n < 256; n++) begin
        acc = acc + perm[n] + key_bytes[n % key_len];
        tmp = perm[n];
        perm[n] = perm[acc];
        perm[acc] = tmp;
      end
      idx_i = '0;
      idx_j = '0;
    endfunction

    function void take_item(in_word_t w);
      out_word_t  r;
      logic [7:0] tmp;
      logic [7:0] ks_idx;
      if (w.mode == MODE_KEY) begin
        // Start a fresh key once the previous one is complete.
        if (key_loaded) begin
          key_loaded = 1'b0;
          key_len    = 0;
        end
        // Drop key bytes past the store size.
        if (key_len < KEY_BYTES_MAX) begin
          key_bytes[key_len] = w.data_value;
          key_len++;
        end
        if (w.last) begin
          schedule_perm();
          key_loaded = 1'b1;
        end
      end else if (!key_loaded) begin
        // Pass the byte through untouched and flag it.
        r.out_byte = w.data_value;
        r.out_last = w.last;
        r.no_key   = 1'b1;
        owed_words.push_back(r);
      end else begin
        // Advance the keystream by one byte.
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm[idx_i];
        tmp = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = tmp;
        ks_idx = perm[idx_i] + perm[idx_j];
        r.out_byte = w.data_value ^ perm[ks_idx];
        r.out_last = w.last;
        r.no_key   = 1'b0;
        owed_words.push_back(r);
        // Restart the keystream for the next message.
        if (w.last) schedule_perm();
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp;
      if (owed_words.size() == 0) begin
        $error("result word with none expected: out_byte %02h out_last %0b no_key %0b",
               got.out_byte, got.out_last, got.no_key);
        errors++;
        return;
      end
      exp = owed_words.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.out_last !== exp.out_last) begin
        $error("out_last: expected %0b, got %0b", exp.out_last, got.out_last);
        errors++;
      end
      if (got.no_key !== exp.no_key) begin
        $error("no_key: expected %0b, got %0b", exp.no_key, got.no_key);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction
  endclass

  logic      clk;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_word_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_word_t result;

  rc4_cipher_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_taken     = 0;
  int unsigned hold_left      = 0;
  int unsigned words_sent     = 0;
  int unsigned quiet_cycles   = 0;

  rc4_stream_cipher_top #(
    .KEY_BYTES_MAX(KEY_BYTES_MAX)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drive result_ready: long holds on request, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ready = 1'b0;
      hold_left--;
    end else if (hold_taken != hold_reqs) begin
      hold_taken++;
      hold_left    = LONG_HOLD - 1;
      result_ready = 1'b0;
    end else begin
      result_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample both handshakes and watch for a hung engine.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.take_item(item);
      if (result_valid && result_ready) sb.check_result(result);
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("rc4_stream_cipher_top_test: FAIL");
        $finish;
      end
    end
  end

  // Offer one word, idling first at random, and hold it until accepted.
  task automatic send_word(input logic mode, input logic [7:0] value, input logic last);
    in_word_t w;
    w.mode       = mode;
    w.data_value = value;
    w.last       = last;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item       = w;
    item_valid = 1'b1;
    do @(posedge clk); while (!(item_valid && item_ready));
    words_sent++;
  endtask

  task automatic send_key(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      send_word(MODE_KEY, 8'($urandom_range(255)), k == len - 1);
    end
  endtask

  task automatic send_message(input int unsigned len);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      send_word(MODE_DATA, 8'($urandom_range(255)), k == len - 1);
    end
  endtask

  initial begin
    int unsigned ph;
    int unsigned phase_start;
    int unsigned pick;
    int unsigned k;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: data before any key passes through flagged.
    send_word(MODE_DATA, 8'h00, 1'b0);
    send_word(MODE_DATA, 8'hFF, 1'b1);
    // One-byte all-zero key, then a message that ends and restarts the keystream.
    send_word(MODE_KEY, 8'h00, 1'b1);
    send_word(MODE_DATA, 8'h00, 1'b0);
    send_word(MODE_DATA, 8'hFF, 1'b0);
    send_word(MODE_DATA, 8'hA5, 1'b1);
    send_word(MODE_DATA, 8'h5A, 1'b1);
    // New key over a ready one; data while it is only partly loaded.
    send_word(MODE_KEY, 8'hFF, 1'b0);
    send_word(MODE_KEY, 8'h80, 1'b0);
    send_word(MODE_DATA, 8'h3C, 1'b0);
    send_word(MODE_DATA, 8'hC3, 1'b1);
    send_word(MODE_KEY, 8'h01, 1'b1);
    send_word(MODE_DATA, 8'hFF, 1'b0);
    send_word(MODE_DATA, 8'h00, 1'b1);
    // Back-to-back one-byte keys.
    send_word(MODE_KEY, 8'h7F, 1'b1);
    send_word(MODE_KEY, 8'hFF, 1'b1);
    send_word(MODE_DATA, 8'h81, 1'b0);
    send_word(MODE_DATA, 8'h7E, 1'b1);

    // Long key: the store fills exactly and the last flag lands on a dropped byte.
    send_key(KEY_BYTES_MAX + $urandom_range(1, 8));
    send_message(8);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      phase_start = words_sent;
      if (ph == 0) begin
        // Once the key schedule is done, hold the output off while a message
        // keeps coming to back up the engine.
        send_key($urandom_range(1, 16));
        send_word(MODE_DATA, 8'($urandom_range(255)), 1'b0);
        hold_reqs++;
        send_message(32);
      end
      while (words_sent - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          send_key($urandom_range(1, 16));
        end else if (pick < 20) begin
          // Broken key: data slips in before the key ends.
          send_word(MODE_KEY, 8'($urandom_range(255)), 1'b0);
          for (k = $urandom_range(1, 3); k > 0; k--) begin
            send_word(MODE_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)));
          end
          send_word(MODE_KEY, 8'($urandom_range(255)), 1'b1);
        end else if (pick < 25) begin
          send_word(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (pick < 28) begin
          send_message($urandom_range(25, 64));
        end else begin
          send_message($urandom_range(1, 24));
        end
      end
    end

    // Drain: wait for every owed word, then for a key schedule to finish.
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("rc4_stream_cipher_top_test: PASS");
    end else begin
      $display("rc4_stream_cipher_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/rc4_pkg.sv
sv/rc4_ram.sv
sv/rc4_stream_cipher_top.sv
tb/sv/rc4_stream_cipher_top_test.sv
